[sv/assert_macros.svh]
// Assertion helpers used by the checker file.
`ifndef ASSERT_MACROS_SVH
`define ASSERT_MACROS_SVH

// Clocked assertion, disabled while reset is held low.
`define ASSERT_CLK(lbl, clk, rst_n, prop, msg) \
  lbl: assert property (@(posedge clk) disable iff (!rst_n) (prop)) \
    else $error(msg);

// Clocked assertion that also holds through reset.
`define ASSERT_ALWAYS(lbl, clk, prop, msg) \
  lbl: assert property (@(posedge clk) (prop)) \
    else $error(msg);

`endif

[sv/cvfm_pkg.sv]
package cvfm_pkg;

  // Controller states
  typedef enum logic [2:0] {
    ST_IDLE,
    ST_SCAN,
    ST_DRAIN,
    ST_EMIT_SUB,
    ST_DIV_START,
    ST_DIV_WAIT,
    ST_EMIT_PACK
  } state_t;

  // Commands from controller to datapath
  typedef struct packed {
    logic store;
    logic eval_start;
    logic rd;
    logic first_cell;
    logic first_sub;
    logic emit_sub;
    logic emit_pack;
    logic div_start;
  } cmd_t;

  // Status from datapath to controller
  typedef struct packed {
    logic out_free;
    logic div_done;
  } stat_t;

  localparam int CFG_IDX_W = 2;
  localparam int CFG_DATA_W = 32;

  // Register indexes
  localparam logic [CFG_IDX_W-1:0] REG_OVER_LIMIT  = 2'd0;
  localparam logic [CFG_IDX_W-1:0] REG_UNDER_LIMIT = 2'd1;
  localparam logic [CFG_IDX_W-1:0] REG_FAULT_LIMIT = 2'd2;
  localparam logic [CFG_IDX_W-1:0] REG_REFRESH     = 2'd3;

  // Operation codes
  localparam logic OP_STORE = 1'b0;
  localparam logic OP_EVAL  = 1'b1;

  // Register reset values
  localparam logic signed [15:0] OVER_LIMIT_RST  = 16'sd18000;
  localparam logic signed [15:0] UNDER_LIMIT_RST = 16'sd6667;
  localparam logic [7:0]         FAULT_LIMIT_RST = 8'd4;
  localparam logic [31:0]        REFRESH_RST     = 32'd5000;

  // Level of a cell that has never been written (0 V)
  localparam logic signed [15:0] UNWRITTEN_LEVEL = -16'sd10000;
  localparam logic [7:0]         COUNT_MAX       = 8'hFF;

endpackage

[sv/cvfm_div.sv]
module cvfm_div #(
  parameter int W       = 24,
  parameter int DIVISOR = 128
) (
  input  logic                clk,
  input  logic                rst_n,
  input  logic                start,
  input  logic signed [W-1:0] dividend,
  output logic                done,
  output logic signed [W-1:0] quotient
);

  // Reciprocal multiply on the magnitude: for every magnitude below 2**W,
  // (m * RECIP) >> SHIFT equals m / DIVISOR rounded down.
  localparam int     LG      = $clog2(DIVISOR);
  localparam int     SHIFT   = W + LG;
  localparam int     RW      = W + 1;
  localparam longint ONE     = 64'sd1;
  localparam longint RECIP_L = ((ONE << SHIFT) + longint'(DIVISOR) - ONE)
                               / longint'(DIVISOR);
  localparam logic [RW-1:0] RECIP = RW'(RECIP_L);

  logic [W-1:0]  mag_r;
  logic          neg_r;
  logic          mul_r;
  logic          done_r;
  logic [2*W:0]  prod_r;
  logic [W-1:0]  q_mag;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      mul_r  <= 1'b0;
      done_r <= 1'b0;
    end else begin
      mul_r  <= start;
      done_r <= mul_r;
    end
  end

  // Stage one: take the magnitude; stage two: multiply
  always_ff @(posedge clk) begin
    if (start) begin
      mag_r <= dividend[W-1] ? W'(~dividend + 1'b1) : W'(dividend);
      neg_r <= dividend[W-1];
    end
    if (mul_r) begin
      prod_r <= mag_r * RECIP;
    end
  end

  assign q_mag    = W'(prod_r >> SHIFT);
  assign done     = done_r;
  assign quotient = neg_r ? $signed(W'(~q_mag + 1'b1)) : $signed(q_mag);

endmodule

[sv/cvfm_datapath.sv]
module cvfm_datapath
  import cvfm_pkg::*;
#(
  parameter int SUBPACKS        = 4,
  parameter int CELLS_PER_GROUP = 32
) (
  input  logic                  clk,
  input  logic                  rst_n,
  input  cmd_t                  cmd,
  output stat_t                 stat,
  input  logic                  cfg_valid,
  input  logic [CFG_IDX_W-1:0]  cfg_index,
  input  logic [CFG_DATA_W-1:0] cfg_data,
  input  logic [1:0]            in_subpack_index,
  input  logic [4:0]            in_cell_index,
  input  logic signed [15:0]    in_sample_raw,
  input  logic [31:0]           in_now_ms,
  input  logic                  out_stall,
  output logic                  out_valid,
  output logic [1:0]            out_record_subpack,
  output logic                  out_is_pack,
  output logic signed [22:0]    out_sum_raw,
  output logic signed [15:0]    out_max_raw,
  output logic signed [15:0]    out_min_raw,
  output logic [15:0]           out_balance_raw,
  output logic signed [15:0]    out_mean_raw,
  output logic                  out_over_flag,
  output logic                  out_under_flag,
  output logic                  out_last
);

  localparam int NCELLS  = SUBPACKS * CELLS_PER_GROUP;
  localparam int ADDR_W  = (NCELLS > 1) ? $clog2(NCELLS) : 1;
  localparam int FULL_W  = 17 + $clog2(NCELLS);
  localparam int PSUM_W  = (FULL_W > 23) ? FULL_W : 23;

  // Configuration registers
  logic signed [15:0] over_lim_r, under_lim_r;
  logic [7:0]         fault_lim_r;
  logic [31:0]        period_r;

  // Cell stores
  logic signed [15:0] level_mem [NCELLS];
  logic [15:0]        cnt_mem   [NCELLS];
  logic [NCELLS-1:0]  written_r;
  logic [NCELLS-1:0]  cnt_ok_r;

  // Scan pipeline
  logic [ADDR_W-1:0]  addr_r, addr_d_r;
  logic               rd_d_r, first_d_r;
  logic signed [15:0] lvl_rd_r;
  logic [15:0]        cnt_rd_r;
  logic               wr_rd_r, ok_rd_r;

  logic [31:0]        last_clear_r;
  logic               over_sticky_r, under_sticky_r;
  logic               clear_due;

  // Store decode
  logic               st_ok;
  logic [31:0]        st_full;
  logic [ADDR_W-1:0]  st_addr;

  // Cell evaluation
  logic signed [15:0] eff, rep;
  logic [7:0]         ovr_old, und_old, ovr_new, und_new;
  logic               ovr_set, und_set;

  // Subpack and pack accumulators
  logic signed [PSUM_W-1:0] ssum_r, ssum_nxt, psum_r, psum_nxt;
  logic signed [15:0] smax_r, smax_nxt, smin_r, smin_nxt;
  logic signed [15:0] smax_rep_r, smax_rep_nxt, smin_rep_r, smin_rep_nxt;
  logic signed [15:0] pmax_r, pmax_nxt, pmin_r, pmin_nxt;
  logic signed [15:0] pmax_rep_r, pmax_rep_nxt, pmin_rep_r, pmin_rep_nxt;
  logic signed [16:0] sbal, pbal;
  logic [1:0]         rec_sp_r;

  // Output register
  logic               out_valid_r, out_valid_nxt;
  logic [1:0]         o_sp_r;
  logic               o_pack_r, o_over_r, o_under_r, o_last_r;
  logic signed [22:0] o_sum_r;
  logic signed [15:0] o_max_r, o_min_r, o_mean_r;
  logic [15:0]        o_bal_r;

  logic                     div_done;
  logic signed [PSUM_W-1:0] div_q;

  cvfm_div #(
    .W       (PSUM_W),
    .DIVISOR (NCELLS)
  ) u_div (
    .clk      (clk),
    .rst_n    (rst_n),
    .start    (cmd.div_start),
    .dividend (psum_r),
    .done     (div_done),
    .quotient (div_q)
  );

  assign clear_due = ((in_now_ms - last_clear_r) > period_r);

  assign st_full = 32'(in_subpack_index) * 32'(CELLS_PER_GROUP) + 32'(in_cell_index);
  assign st_addr = st_full[ADDR_W-1:0];
  assign st_ok   = cmd.store
                && (32'(in_subpack_index) < 32'(SUBPACKS))
                && (32'(in_cell_index) < 32'(CELLS_PER_GROUP))
                && (in_sample_raw != 16'sd0);

  always_comb begin
    eff     = wr_rd_r ? lvl_rd_r : UNWRITTEN_LEVEL;
    rep     = wr_rd_r ? lvl_rd_r : 16'sd0;
    ovr_old = ok_rd_r ? cnt_rd_r[15:8] : 8'd0;
    und_old = ok_rd_r ? cnt_rd_r[7:0]  : 8'd0;
    ovr_new = ovr_old;
    und_new = und_old;
    ovr_set = 1'b0;
    und_set = 1'b0;
    if (eff > over_lim_r) begin
      ovr_new = (ovr_old == COUNT_MAX) ? ovr_old : ovr_old + 1'b1;
      ovr_set = (ovr_new > fault_lim_r);
    end else if (eff < under_lim_r) begin
      und_new = (und_old == COUNT_MAX) ? und_old : und_old + 1'b1;
      und_set = (und_new > fault_lim_r);
    end
  end

  // Subpack statistics: first highest and first lowest cell win ties
  always_comb begin
    smax_nxt     = smax_r;
    smax_rep_nxt = smax_rep_r;
    smin_nxt     = smin_r;
    smin_rep_nxt = smin_rep_r;
    ssum_nxt     = ssum_r;
    if (rd_d_r) begin
      if (first_d_r || (eff > smax_r)) begin
        smax_nxt     = eff;
        smax_rep_nxt = rep;
      end
      if (first_d_r || (eff < smin_r)) begin
        smin_nxt     = eff;
        smin_rep_nxt = rep;
      end
      ssum_nxt = first_d_r ? PSUM_W'(eff) : ssum_r + PSUM_W'(eff);
    end
  end

  always_comb begin
    pmax_nxt     = pmax_r;
    pmax_rep_nxt = pmax_rep_r;
    pmin_nxt     = pmin_r;
    pmin_rep_nxt = pmin_rep_r;
    psum_nxt     = psum_r;
    if (cmd.emit_sub) begin
      if (cmd.first_sub || (smax_r > pmax_r)) begin
        pmax_nxt     = smax_r;
        pmax_rep_nxt = smax_rep_r;
      end
      if (cmd.first_sub || (smin_r < pmin_r)) begin
        pmin_nxt     = smin_r;
        pmin_rep_nxt = smin_rep_r;
      end
      psum_nxt = cmd.first_sub ? ssum_r : psum_r + ssum_r;
    end
  end

  assign sbal = {smax_r[15], smax_r} - {smin_r[15], smin_r};
  assign pbal = {pmax_r[15], pmax_r} - {pmin_r[15], pmin_r};

  assign out_valid_nxt = (cmd.emit_sub || cmd.emit_pack) ? 1'b1 : (out_valid_r && out_stall);

  // Control state
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      over_lim_r     <= OVER_LIMIT_RST;
      under_lim_r    <= UNDER_LIMIT_RST;
      fault_lim_r    <= FAULT_LIMIT_RST;
      period_r       <= REFRESH_RST;
      written_r      <= '0;
      cnt_ok_r       <= '0;
      last_clear_r   <= '0;
      over_sticky_r  <= 1'b0;
      under_sticky_r <= 1'b0;
      addr_r         <= '0;
      rd_d_r         <= 1'b0;
      rec_sp_r       <= '0;
      out_valid_r    <= 1'b0;
    end else begin
      if (cfg_valid) begin
        unique case (cfg_index)
          REG_OVER_LIMIT:  over_lim_r  <= $signed(cfg_data[15:0]);
          REG_UNDER_LIMIT: under_lim_r <= $signed(cfg_data[15:0]);
          REG_FAULT_LIMIT: fault_lim_r <= cfg_data[7:0];
          REG_REFRESH:     period_r    <= cfg_data;
          default: ;
        endcase
      end
      if (st_ok) begin
        written_r[st_addr] <= 1'b1;
      end
      if (cmd.eval_start && clear_due) begin
        cnt_ok_r     <= '0;
        last_clear_r <= in_now_ms;
      end else if (rd_d_r) begin
        cnt_ok_r[addr_d_r] <= 1'b1;
      end
      if (rd_d_r && ovr_set) begin
        over_sticky_r <= 1'b1;
      end
      if (rd_d_r && und_set) begin
        under_sticky_r <= 1'b1;
      end
      if (cmd.eval_start) begin
        addr_r <= '0;
      end else if (cmd.rd) begin
        addr_r <= addr_r + 1'b1;
      end
      rd_d_r <= cmd.rd;
      if (cmd.eval_start) begin
        rec_sp_r <= '0;
      end else if (cmd.emit_sub) begin
        rec_sp_r <= rec_sp_r + 1'b1;
      end
      out_valid_r <= out_valid_nxt;
    end
  end

  // Memories and payload
  always_ff @(posedge clk) begin
    if (st_ok) begin
      level_mem[st_addr] <= in_sample_raw;
    end
    if (cmd.rd) begin
      lvl_rd_r <= level_mem[addr_r];
      cnt_rd_r <= cnt_mem[addr_r];
      wr_rd_r  <= written_r[addr_r];
      ok_rd_r  <= cnt_ok_r[addr_r];
    end
    if (rd_d_r) begin
      cnt_mem[addr_d_r] <= {ovr_new, und_new};
    end
    addr_d_r   <= addr_r;
    first_d_r  <= cmd.first_cell;
    ssum_r     <= ssum_nxt;
    smax_r     <= smax_nxt;
    smin_r     <= smin_nxt;
    smax_rep_r <= smax_rep_nxt;
    smin_rep_r <= smin_rep_nxt;
    psum_r     <= psum_nxt;
    pmax_r     <= pmax_nxt;
    pmin_r     <= pmin_nxt;
    pmax_rep_r <= pmax_rep_nxt;
    pmin_rep_r <= pmin_rep_nxt;
    if (cmd.emit_sub) begin
      o_sp_r    <= rec_sp_r;
      o_pack_r  <= 1'b0;
      o_sum_r   <= ssum_r[22:0];
      o_max_r   <= smax_rep_r;
      o_min_r   <= smin_rep_r;
      o_bal_r   <= sbal[15:0];
      o_mean_r  <= 16'sd0;
      o_over_r  <= over_sticky_r;
      o_under_r <= under_sticky_r;
      o_last_r  <= 1'b0;
    end else if (cmd.emit_pack) begin
      o_sp_r    <= 2'd0;
      o_pack_r  <= 1'b1;
      o_sum_r   <= psum_r[22:0];
      o_max_r   <= pmax_rep_r;
      o_min_r   <= pmin_rep_r;
      o_bal_r   <= pbal[15:0];
      o_mean_r  <= div_q[15:0];
      o_over_r  <= over_sticky_r;
      o_under_r <= under_sticky_r;
      o_last_r  <= 1'b1;
    end
  end

  assign stat.out_free = !out_valid_r || !out_stall;
  assign stat.div_done = div_done;

  assign out_valid          = out_valid_r;
  assign out_record_subpack = o_sp_r;
  assign out_is_pack        = o_pack_r;
  assign out_sum_raw        = o_sum_r;
  assign out_max_raw        = o_max_r;
  assign out_min_raw        = o_min_r;
  assign out_balance_raw    = o_bal_r;
  assign out_mean_raw       = o_mean_r;
  assign out_over_flag      = o_over_r;
  assign out_under_flag     = o_under_r;
  assign out_last           = o_last_r;

endmodule

[sv/cvfm_ctrl.sv]
module cvfm_ctrl
  import cvfm_pkg::*;
#(
  parameter int SUBPACKS        = 4,
  parameter int CELLS_PER_GROUP = 32
) (
  input  logic  clk,
  input  logic  rst_n,
  input  logic  in_valid,
  input  logic  in_op,
  output logic  in_stall,
  input  stat_t stat,
  output cmd_t  cmd
);

  localparam int CW = (CELLS_PER_GROUP > 1) ? $clog2(CELLS_PER_GROUP) : 1;
  localparam int SW = (SUBPACKS > 1) ? $clog2(SUBPACKS) : 1;
  localparam logic [CW-1:0] LAST_CELL = CW'(CELLS_PER_GROUP - 1);
  localparam logic [SW-1:0] LAST_SUB  = SW'(SUBPACKS - 1);

  state_t        state_r, state_nxt;
  logic [CW-1:0] cell_r, cell_nxt;
  logic [SW-1:0] sp_r, sp_nxt;
  logic          in_fire;

  assign in_fire = in_valid && !in_stall;

  always_comb begin
    state_nxt = state_r;
    cell_nxt  = cell_r;
    sp_nxt    = sp_r;
    unique case (state_r)
      ST_IDLE: begin
        if (in_fire && (in_op == OP_EVAL)) begin
          state_nxt = ST_SCAN;
          cell_nxt  = '0;
          sp_nxt    = '0;
        end
      end
      ST_SCAN: begin
        cell_nxt = cell_r + 1'b1;
        if (cell_r == LAST_CELL) begin
          state_nxt = ST_DRAIN;
        end
      end
      ST_DRAIN: state_nxt = ST_EMIT_SUB;
      ST_EMIT_SUB: begin
        if (stat.out_free) begin
          if (sp_r == LAST_SUB) begin
            state_nxt = ST_DIV_START;
          end else begin
            state_nxt = ST_SCAN;
            sp_nxt    = sp_r + 1'b1;
            cell_nxt  = '0;
          end
        end
      end
      ST_DIV_START: state_nxt = ST_DIV_WAIT;
      ST_DIV_WAIT: begin
        if (stat.div_done) begin
          state_nxt = ST_EMIT_PACK;
        end
      end
      ST_EMIT_PACK: begin
        if (stat.out_free) begin
          state_nxt = ST_IDLE;
        end
      end
      default: state_nxt = ST_IDLE;
    endcase
  end

  always_comb begin
    in_stall       = (state_r != ST_IDLE);
    cmd            = '0;
    cmd.store      = (state_r == ST_IDLE) && in_fire && (in_op == OP_STORE);
    cmd.eval_start = (state_r == ST_IDLE) && in_fire && (in_op == OP_EVAL);
    cmd.rd         = (state_r == ST_SCAN);
    cmd.first_cell = (state_r == ST_SCAN) && (cell_r == '0);
    cmd.first_sub  = (state_r == ST_EMIT_SUB) && (sp_r == '0);
    cmd.emit_sub   = (state_r == ST_EMIT_SUB) && stat.out_free;
    cmd.emit_pack  = (state_r == ST_EMIT_PACK) && stat.out_free;
    cmd.div_start  = (state_r == ST_DIV_START);
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r <= ST_IDLE;
      cell_r  <= '0;
      sp_r    <= '0;
    end else begin
      state_r <= state_nxt;
      cell_r  <= cell_nxt;
      sp_r    <= sp_nxt;
    end
  end

endmodule

[sv/cell_voltage_fault_monitor.sv]
// Cell voltage fault monitor, working in raw converter codes.
// Input channel (in_valid / in_stall): a store transaction (op 0) writes one
// cell sample if nonzero and in range; stores can follow back to back.
// An evaluate transaction (op 1) checks the refresh period, then scans every
// cell one per cycle from the cell memory, emitting one record per subpack
// and a final pack record carrying the mean and last.
// Each subpack is scanned, drained and handed over as a record; the mean
// then comes from the pipelined reciprocal multiply (magnitude and multiply
// stages) before the pack record is handed over. in_stall stays high for
// the whole pass.
// Output channel (out_valid / out_stall): records sit in an output register;
// when the receiver stalls, the register holds and the scan pauses before the
// next record, so nothing is lost. The next input can be taken while the pack
// record still waits.
// Configuration (cfg_valid / cfg_ready): ready is always high; write only
// while the block is idle.
// Reset (rst_n low, synchronous): registers return to their defaults, all
// cells read as unwritten, counters and sticky flags are cleared at once.
module cell_voltage_fault_monitor
  import cvfm_pkg::*;
#(
  parameter int SUBPACKS        = 4,
  parameter int CELLS_PER_GROUP = 32
) (
  input  logic                  clk,
  input  logic                  rst_n,
  input  logic                  in_valid,
  output logic                  in_stall,
  input  logic                  in_op,
  input  logic [1:0]            in_subpack_index,
  input  logic [4:0]            in_cell_index,
  input  logic signed [15:0]    in_sample_raw,
  input  logic [31:0]           in_now_ms,
  output logic                  out_valid,
  input  logic                  out_stall,
  output logic [1:0]            out_record_subpack,
  output logic                  out_is_pack,
  output logic signed [22:0]    out_sum_raw,
  output logic signed [15:0]    out_max_raw,
  output logic signed [15:0]    out_min_raw,
  output logic [15:0]           out_balance_raw,
  output logic signed [15:0]    out_mean_raw,
  output logic                  out_over_flag,
  output logic                  out_under_flag,
  output logic                  out_last,
  input  logic                  cfg_valid,
  output logic                  cfg_ready,
  input  logic [CFG_IDX_W-1:0]  cfg_index,
  input  logic [CFG_DATA_W-1:0] cfg_data
);

  cmd_t  cmd;
  stat_t stat;

  // Register writes are always taken
  assign cfg_ready = 1'b1;

  // Sequencer: store decode, cell scan, record hand-over, mean divide
  cvfm_ctrl #(
    .SUBPACKS        (SUBPACKS),
    .CELLS_PER_GROUP (CELLS_PER_GROUP)
  ) u_ctrl (
    .clk      (clk),
    .rst_n    (rst_n),
    .in_valid (in_valid),
    .in_op    (in_op),
    .in_stall (in_stall),
    .stat     (stat),
    .cmd      (cmd)
  );

  // Cell memory, fault counters, statistics and output register
  cvfm_datapath #(
    .SUBPACKS        (SUBPACKS),
    .CELLS_PER_GROUP (CELLS_PER_GROUP)
  ) u_dp (
    .clk                (clk),
    .rst_n              (rst_n),
    .cmd                (cmd),
    .stat               (stat),
    .cfg_valid          (cfg_valid && cfg_ready),
    .cfg_index          (cfg_index),
    .cfg_data           (cfg_data),
    .in_subpack_index   (in_subpack_index),
    .in_cell_index      (in_cell_index),
    .in_sample_raw      (in_sample_raw),
    .in_now_ms          (in_now_ms),
    .out_stall          (out_stall),
    .out_valid          (out_valid),
    .out_record_subpack (out_record_subpack),
    .out_is_pack        (out_is_pack),
    .out_sum_raw        (out_sum_raw),
    .out_max_raw        (out_max_raw),
    .out_min_raw        (out_min_raw),
    .out_balance_raw    (out_balance_raw),
    .out_mean_raw       (out_mean_raw),
    .out_over_flag      (out_over_flag),
    .out_under_flag     (out_under_flag),
    .out_last           (out_last)
  );

endmodule

[sv/cvfm_chk.sv]
`include "assert_macros.svh"

module cvfm_chk (
  input logic               clk,
  input logic               rst_n,
  input logic               out_valid,
  input logic               out_stall,
  input logic [1:0]         out_record_subpack,
  input logic               out_is_pack,
  input logic signed [22:0] out_sum_raw,
  input logic signed [15:0] out_mean_raw,
  input logic               out_last
);

  // A stalled record holds
  `ASSERT_CLK(a_out_hold, clk, rst_n, out_valid && out_stall |=> out_valid && $stable(out_sum_raw) && $stable(out_last), "stalled record changed")

  // Only the pack record closes a pass
  `ASSERT_CLK(a_last_pack, clk, rst_n, out_valid |-> (out_is_pack == out_last), "last and is_pack disagree")

  // Pack record carries subpack zero
  `ASSERT_CLK(a_pack_sub, clk, rst_n, out_valid && out_is_pack |-> (out_record_subpack == 2'd0), "pack record subpack not zero")

  // Subpack records carry no mean
  `ASSERT_CLK(a_sub_mean, clk, rst_n, out_valid && !out_is_pack |-> (out_mean_raw == 16'sd0), "subpack record mean not zero")

endmodule

bind cell_voltage_fault_monitor cvfm_chk u_chk (.*);
